FILE: hdl/variable_interaction_matrix_unit_defines.svh
// ----------------------------------------------------------------------------
// Variable interaction matrix - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_INTERACTION_MATRIX_UNIT_DEFINES_SVH
`define VARIABLE_INTERACTION_MATRIX_UNIT_DEFINES_SVH

// same-cycle implication
`define VIM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define VIM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/vim_pkg.sv
// ----------------------------------------------------------------------------
// Variable interaction matrix - package
// Shared sizes, word codes and the row memory request type.
// ----------------------------------------------------------------------------
package vim_pkg;

    localparam int MAX_VARS = 64;
    localparam int VAR_W    = 6;
    localparam int CNT_W    = 7;
    localparam int KIND_W   = 2;

    localparam logic [CNT_W-1:0] NUM_VARS_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_MARK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic                rd_en;
        logic [VAR_W-1:0]    rd_addr;
        logic                wr_en;
        logic [VAR_W-1:0]    wr_addr;
        logic [MAX_VARS-1:0] wr_data;
    } mem_req_t;

endpackage

FILE: hdl/vim_row_mem.sv
// ----------------------------------------------------------------------------
// Variable interaction matrix - row memory
// One row per variable, registered read, per-row valid bits cleared at reset.
// ----------------------------------------------------------------------------
module vim_row_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vim_pkg::mem_req_t           req,
    output logic [vim_pkg::MAX_VARS-1:0] rd_row
);

    logic [vim_pkg::MAX_VARS-1:0] mem_reg [vim_pkg::MAX_VARS];
    logic [vim_pkg::MAX_VARS-1:0] rd_data_reg;
    logic [vim_pkg::MAX_VARS-1:0] row_valid_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    // unwritten rows read as zero
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/vim_ctrl.sv
// ----------------------------------------------------------------------------
// Variable interaction matrix - sequencer
// Support bitmap, commit row walk with one shared mask/OR unit, query path.
// ----------------------------------------------------------------------------
module vim_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vim_pkg::KIND_W-1:0]    kind,
    input  logic [vim_pkg::VAR_W-1:0]     var_a,
    input  logic [vim_pkg::VAR_W-1:0]     var_b,
    input  logic [vim_pkg::CNT_W-1:0]     n_active,
    output vim_pkg::mem_req_t             mem_req,
    input  logic [vim_pkg::MAX_VARS-1:0]  rd_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          interacts
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WR, ST_QRY} state_t;

    state_t                       state_reg,     state_next;
    logic [vim_pkg::MAX_VARS-1:0] support_reg,   support_next;
    logic [vim_pkg::MAX_VARS-1:0] marked_reg,    marked_next;
    logic [vim_pkg::CNT_W-1:0]    row_reg,       row_next;
    logic [vim_pkg::VAR_W-1:0]    col_reg,       col_next;
    logic                         hit_reg,       hit_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         interacts_reg, interacts_next;

    logic                         accept;
    logic [vim_pkg::VAR_W-1:0]    a_lo;
    logic [vim_pkg::VAR_W-1:0]    a_hi;
    logic                         q_hit;
    logic [vim_pkg::MAX_VARS-1:0] n_mask;
    logic [vim_pkg::MAX_VARS-1:0] above;
    logic                         row_done;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign a_lo     = (var_a < var_b) ? var_a : var_b;
    assign a_hi     = (var_a < var_b) ? var_b : var_a;
    assign q_hit    = (a_lo != a_hi) && ({1'b0, a_hi} < n_active);
    assign n_mask   = n_active[vim_pkg::CNT_W-1] ? '1 :
                      (({{(vim_pkg::MAX_VARS-1){1'b0}}, 1'b1} << n_active[vim_pkg::VAR_W-1:0])
                       - {{(vim_pkg::MAX_VARS-1){1'b0}}, 1'b1});
    assign above    = ({vim_pkg::MAX_VARS{1'b1}} << row_reg[vim_pkg::VAR_W-1:0]) << 1;
    assign row_done = (row_reg >= n_active);

    always_comb
    begin
        state_next     = state_reg;
        support_next   = support_reg;
        marked_next    = marked_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        interacts_next = interacts_reg;

        mem_req         = '0;
        mem_req.rd_addr = a_lo;
        mem_req.wr_addr = row_reg[vim_pkg::VAR_W-1:0];
        mem_req.wr_data = rd_row | (marked_reg & above);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        vim_pkg::KIND_MARK:
                        begin
                            if ({1'b0, var_a} < n_active)
                            begin
                                support_next[var_a] = 1'b1;
                            end
                        end
                        vim_pkg::KIND_COMMIT:
                        begin
                            marked_next  = support_reg & n_mask;
                            support_next = '0;
                            row_next     = '0;
                            state_next   = ST_SCAN;
                        end
                        vim_pkg::KIND_QUERY:
                        begin
                            mem_req.rd_en = 1'b1;
                            col_next      = a_hi;
                            hit_next      = q_hit;
                            state_next    = ST_QRY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (row_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (marked_reg[row_reg[vim_pkg::VAR_W-1:0]])
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = row_reg[vim_pkg::VAR_W-1:0];
                    state_next      = ST_WR;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_WR:
            begin
                mem_req.wr_en = 1'b1;
                row_next      = row_reg + 1'b1;
                state_next    = ST_SCAN;
            end
            ST_QRY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    interacts_next = hit_reg & rd_row[col_reg];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            support_reg   <= '0;
            marked_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            interacts_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            support_reg   <= support_next;
            marked_reg    <= marked_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            interacts_reg <= interacts_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign interacts = interacts_reg;

endmodule

FILE: hdl/variable_interaction_matrix_unit.sv
// ----------------------------------------------------------------------------
// Variable interaction matrix - top level
// Pair interaction bit matrix with support bitmap, mark/commit/query words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): kind, var_a, var_b. Output channel
// (out_valid/out_stall): interacts, one word per query only.
// cfg_we/cfg_wdata writes num_vars (sizes above 64 act as 64); write only
// while idle.
// Mark and unused kinds: accepted back to back.
// Query: row read issued on accept and registered in the row memory, then
// the result registered from ST_QRY; in_stall is high until it is loaded.
// Commit: the accept, a scan step for each active row plus a closing check,
// and a write step after each marked row's scan (read, then write back
// through the row memory).
// A waiting result does not block marks or commits; a second query holds
// in_stall until the receiver takes the first word.
// Reset clears the support bitmap, row valid bits and output, sets num_vars
// to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module variable_interaction_matrix_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vim_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vim_pkg::KIND_W-1:0]    kind,
    input  logic [vim_pkg::VAR_W-1:0]     var_a,
    input  logic [vim_pkg::VAR_W-1:0]     var_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          interacts
);

    logic [vim_pkg::CNT_W-1:0]    num_vars_reg;
    logic [vim_pkg::CNT_W-1:0]    n_active;
    vim_pkg::mem_req_t            mem_req;
    logic [vim_pkg::MAX_VARS-1:0] rd_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= vim_pkg::NUM_VARS_RESET;
        end
        else if (cfg_we)
        begin
            num_vars_reg <= cfg_wdata;
        end
    end

    assign n_active = (num_vars_reg > vim_pkg::CNT_W'(vim_pkg::MAX_VARS)) ?
                      vim_pkg::CNT_W'(vim_pkg::MAX_VARS) : num_vars_reg;

    vim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .var_a     (var_a),
        .var_b     (var_b),
        .n_active  (n_active),
        .mem_req   (mem_req),
        .rd_row    (rd_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .interacts (interacts)
    );

    vim_row_mem u_row_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (rd_row)
    );

endmodule

FILE: hdl/vim_checker.sv
// ----------------------------------------------------------------------------
// Variable interaction matrix - port checker
// Timing checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_interaction_matrix_unit_defines.svh"

module vim_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [vim_pkg::CNT_W-1:0]     cfg_wdata,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [vim_pkg::KIND_W-1:0]    kind,
    input logic [vim_pkg::VAR_W-1:0]     var_a,
    input logic [vim_pkg::VAR_W-1:0]     var_b,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          interacts
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    `VIM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(interacts), "stalled result word changed")
    `VIM_ASSERT_NEXT(a_mark_ready, in_acc && (kind == vim_pkg::KIND_MARK), !in_stall && !$rose(out_valid), "mark word not single cycle")
    `VIM_ASSERT_NEXT(a_query_busy, in_acc && (kind == vim_pkg::KIND_QUERY), in_stall, "query word did not hold input")
    `VIM_ASSERT_NOW(a_out_src, $rose(out_valid), $past(in_stall), "result word without a pending query")

endmodule

bind variable_interaction_matrix_unit vim_checker u_vim_checker (.*);
